[design/emt_pkg.sv]
// shared types, constants and helper functions for the encoder master transceiver
package emt_pkg;

    localparam int SEND_BITS_POS  = 6;
    localparam int SEND_BITS_CMD  = 30;
    localparam int CMD_DATA_BITS  = 24;
    localparam int CRC_BITS       = 5;
    localparam int CNT_W          = 7;
    localparam int POS_W          = 48;
    localparam logic [4:0] CRC_SEED          = 5'h1f;
    localparam logic [5:0] POSITION_BITS_RST = 6'd32;

    localparam int STAT_ERR  = 0;
    localparam int STAT_CRC  = 1;
    localparam int STAT_ADDR = 2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEND = 3'd1,
        PH_WAIT = 3'd2,
        PH_FBIT = 3'd3,
        PH_DATA = 3'd4,
        PH_CRC  = 3'd5
    } phase_t;

    typedef struct packed {
        logic        start_req;
        logic        mode_type;
        logic [5:0]  mode_bits;
        logic [7:0]  address;
        logic [15:0] param_word;
        logic        din;
    } emt_item_t;

    typedef struct packed {
        logic        clock_line;
        logic        data_out_line;
        logic        drive_enable;
        logic        busy_res;
        logic        done_res;
        logic [47:0] position;
        logic [7:0]  rx_address;
        logic [15:0] rx_data;
        logic [2:0]  status;
    } emt_result_t;

    // one step of the check lfsr, bit k is flip-flop k
    function automatic logic [4:0] crc_step(logic [4:0] f, logic b);
        logic ex;
        ex = f[4] ^ b;
        return {f[3], f[2] ^ ex, f[1], f[0] ^ ex, ex};
    endfunction

endpackage

[design/endat_master_transceiver_top.sv]
// top level of the encoder master transceiver
//
// each input transfer on the s_axis channel is one period of the encoder clock,
// carrying the start request, command fields and the sampled data line level.
// each accepted item yields exactly one result transfer on m_axis with the
// clock line level, driven data level, drive enable, busy/done flags and, on
// the completing item, the position or the received address and data word.
// status always shows the last completed transfer.
// cfg_valid/cfg_data write the position bit count (reset 32); write it only
// while no transfer is in progress.
// an item passes through the input register, then the result register.
// throughput: one item per cycle while the result register is not stalled,
// bound by the single step of the state update between the two registers.
// reset clears the protocol state to idle and empties both register stages.
// when m_axis_tready is low the result register holds and the input register
// still takes one more item; s_axis_tready drops only while both are full.
module endat_master_transceiver_top #(
    parameter int MAX_POSITION_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_req, mode_bits, address, param_word, din
    input  logic [31:0] s_axis_tdata,
    // mode_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // clock_line, data_out_line, drive_enable, busy_res, done_res, position,
    // rx_address, rx_data, status
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import emt_pkg::*;

    emt_item_t   s_item;
    emt_item_t   item;
    emt_result_t result;
    emt_result_t m_result;
    logic        item_valid;
    logic        advance;
    logic        step;

    assign s_item.start_req  = s_axis_tdata[0];
    assign s_item.mode_type  = s_axis_tuser;
    assign s_item.mode_bits  = s_axis_tdata[6:1];
    assign s_item.address    = s_axis_tdata[14:7];
    assign s_item.param_word = s_axis_tdata[30:15];
    assign s_item.din        = s_axis_tdata[31];

    assign cfg_ready = 1'b1;
    assign step      = item_valid && advance;

    emt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    emt_core #(
        .MAX_POSITION_BITS (MAX_POSITION_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_position_bits (cfg_data),
        .step              (step),
        .item              (item),
        .result            (result)
    );

    emt_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_valid),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {m_result.status, m_result.rx_data, m_result.rx_address,
                           m_result.position, m_result.done_res, m_result.busy_res,
                           m_result.drive_enable, m_result.data_out_line,
                           m_result.clock_line};

    // input side stalls only behind a full, stalled result register
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while result register free");

    // a buffered item moves into the result register when that register is taken
    a_item_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_axis_tvalid && m_axis_tready) |=> m_axis_tvalid)
        else $error("buffered item lost");

    // a completing result always releases the clock line and clears busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done_res) |=> (!m_result.busy_res && m_result.clock_line))
        else $error("completion result not idle");

endmodule

[design/emt_in_reg.sv]
// input register stage of the encoder master transceiver
module emt_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  emt_pkg::emt_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output emt_pkg::emt_item_t item
);
    import emt_pkg::*;

    logic      valid_reg;
    emt_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

[design/emt_core.sv]
// protocol state and per-clock-period step of the encoder master transceiver
module emt_core #(
    parameter int MAX_POSITION_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_position_bits,
    input  logic                 step,
    input  emt_pkg::emt_item_t   item,
    output emt_pkg::emt_result_t result
);
    import emt_pkg::*;

    localparam int RW = (MAX_POSITION_BITS > CMD_DATA_BITS) ? MAX_POSITION_BITS
                                                             : CMD_DATA_BITS;

    phase_t      phase_reg, phase_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic [29:0] tx_shift_reg, tx_shift_next;
    logic [RW-1:0] rx_shift_reg, rx_shift_next;
    logic [4:0]  lfsr_reg, lfsr_next;
    logic [4:0]  crc_rx_reg, crc_rx_next;
    logic        err_bit_reg, err_bit_next;
    logic [7:0]  sent_addr_reg, sent_addr_next;
    logic        kind_reg, kind_next;
    logic [2:0]  last_status_reg, last_status_next;
    logic [5:0]  position_bits_reg;

    logic [CNT_W-1:0] data_cnt;
    logic [CNT_W-1:0] pos_cnt;
    logic [5:0]  send_len;
    logic [5:0]  bit_inc;
    logic [2:0]  stat;
    logic [7:0]  addr_rev;
    logic [15:0] word_rev;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            addr_rev[k] = item.address[7-k];
        end
        for (int k = 0; k < 16; k++)
        begin
            word_rev[k] = item.param_word[15-k];
        end
    end

    // position count saturates at MAX_POSITION_BITS
    always_comb
    begin
        pos_cnt = CNT_W'(position_bits_reg);
        if (pos_cnt > CNT_W'(MAX_POSITION_BITS))
        begin
            pos_cnt = CNT_W'(MAX_POSITION_BITS);
        end
        data_cnt = kind_reg ? CNT_W'(CMD_DATA_BITS) : pos_cnt;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        lfsr_next        = lfsr_reg;
        crc_rx_next      = crc_rx_reg;
        err_bit_next     = err_bit_reg;
        sent_addr_next   = sent_addr_reg;
        kind_next        = kind_reg;
        last_status_next = last_status_reg;
        send_len         = kind_reg ? 6'(SEND_BITS_CMD) : 6'(SEND_BITS_POS);
        bit_inc          = bit_cnt_reg + 6'd1;
        stat             = '0;

        result               = '0;
        result.clock_line    = 1'b0;
        result.busy_res      = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    // first clock of the transfer: data line still released
                    kind_next      = item.mode_type;
                    tx_shift_next  = item.mode_type ? {word_rev, addr_rev, item.mode_bits}
                                                    : {24'd0, item.mode_bits};
                    sent_addr_next = item.address;
                    rx_shift_next  = '0;
                    lfsr_next      = CRC_SEED;
                    crc_rx_next    = '0;
                    err_bit_next   = 1'b0;
                    bit_cnt_next   = 6'd1;
                    phase_next     = PH_SEND;
                end
                else
                begin
                    result.clock_line = 1'b1;
                    result.busy_res   = 1'b0;
                end
            end
            PH_SEND:
            begin
                result.drive_enable = (bit_cnt_reg < send_len + 6'd2);
                if (bit_cnt_reg >= 6'd2 && bit_cnt_reg < send_len + 6'd2)
                begin
                    result.data_out_line = tx_shift_reg[0];
                    tx_shift_next        = {1'b0, tx_shift_reg[29:1]};
                end
                bit_cnt_next = bit_inc;
                if (bit_inc >= send_len + 6'd4)
                begin
                    bit_cnt_next = '0;
                    phase_next   = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                // no timeout on the start bit
                if (item.din)
                begin
                    bit_cnt_next = '0;
                    phase_next   = kind_reg ? PH_DATA : PH_FBIT;
                end
            end
            PH_FBIT:
            begin
                err_bit_next = item.din;
                lfsr_next    = crc_step(lfsr_reg, item.din);
                bit_cnt_next = '0;
                phase_next   = (data_cnt == '0) ? PH_CRC : PH_DATA;
            end
            PH_DATA:
            begin
                lfsr_next = crc_step(lfsr_reg, item.din);
                if (kind_reg)
                begin
                    rx_shift_next = '0;
                    rx_shift_next[CMD_DATA_BITS-1:0] =
                        {rx_shift_reg[CMD_DATA_BITS-2:0], item.din};
                end
                else
                begin
                    for (int k = 0; k < RW; k++)
                    begin
                        if (32'(bit_cnt_reg) == k)
                        begin
                            rx_shift_next[k] = rx_shift_reg[k] | item.din;
                        end
                    end
                end
                bit_cnt_next = bit_inc;
                if (CNT_W'(bit_inc) >= data_cnt)
                begin
                    bit_cnt_next = '0;
                    phase_next   = PH_CRC;
                end
            end
            PH_CRC:
            begin
                crc_rx_next  = {crc_rx_reg[3:0], item.din};
                bit_cnt_next = bit_inc;
                if (bit_inc >= 6'(CRC_BITS))
                begin
                    stat[STAT_ERR] = err_bit_reg;
                    stat[STAT_CRC] = (crc_rx_next != ~lfsr_reg);
                    if (kind_reg)
                    begin
                        result.rx_address = rx_shift_reg[23:16];
                        result.rx_data    = rx_shift_reg[15:0];
                        stat[STAT_ADDR]   = (rx_shift_reg[23:16] != sent_addr_reg);
                    end
                    else
                    begin
                        for (int k = 0; k < POS_W; k++)
                        begin
                            if (k < RW)
                            begin
                                result.position[k] = rx_shift_reg[k];
                            end
                        end
                    end
                    last_status_next  = stat;
                    bit_cnt_next      = '0;
                    phase_next        = PH_IDLE;
                    result.clock_line = 1'b1;
                    result.busy_res   = 1'b0;
                    result.done_res   = 1'b1;
                end
            end
            default:
            begin
                phase_next        = PH_IDLE;
                bit_cnt_next      = '0;
                result.clock_line = 1'b1;
                result.busy_res   = 1'b0;
            end
        endcase

        result.status = last_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_cnt_reg       <= '0;
            tx_shift_reg      <= '0;
            rx_shift_reg      <= '0;
            lfsr_reg          <= CRC_SEED;
            crc_rx_reg        <= '0;
            err_bit_reg       <= 1'b0;
            sent_addr_reg     <= '0;
            kind_reg          <= 1'b0;
            last_status_reg   <= '0;
            position_bits_reg <= POSITION_BITS_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                position_bits_reg <= cfg_position_bits;
            end
            if (step)
            begin
                phase_reg       <= phase_next;
                bit_cnt_reg     <= bit_cnt_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
                lfsr_reg        <= lfsr_next;
                crc_rx_reg      <= crc_rx_next;
                err_bit_reg     <= err_bit_next;
                sent_addr_reg   <= sent_addr_next;
                kind_reg        <= kind_next;
                last_status_reg <= last_status_next;
            end
        end
    end

endmodule

[design/emt_out_reg.sv]
// result register stage of the encoder master transceiver
module emt_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  emt_pkg::emt_result_t result,
    output logic                 advance,
    output logic                 m_valid,
    input  logic                 m_ready,
    output emt_pkg::emt_result_t m_result
);
    import emt_pkg::*;

    logic        valid_reg;
    emt_result_t result_reg;

    assign advance  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && advance)
        begin
            result_reg <= result;
        end
    end

endmodule

[verif/tb_endat_master_transceiver_top.sv]
// testbench for the encoder master transceiver: protocol-level predictor with in-order result checking
`timescale 1ns / 1ps

module tb_endat_master_transceiver_top;
    import emt_pkg::*;

    localparam int MAX_POS_BITS = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    // predictor state
    phase_t      enc_phase;
    logic [5:0]  step_count;
    logic [29:0] tx_bits;
    logic [47:0] rx_bits;
    logic [4:0]  crc_acc;
    logic [4:0]  crc_in;
    logic        err_flag;
    logic [7:0]  sent_addr;
    logic        cmd_kind;
    logic [2:0]  last_stat;
    logic [5:0]  pos_bits_reg;

    emt_result_t expected_periods[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles = 0;

    endat_master_transceiver_top #(
        .MAX_POSITION_BITS(MAX_POS_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // check lfsr, bit k is flip-flop k
    function automatic logic [4:0] crc_shift(input logic [4:0] r, input logic b);
        logic fb;
        fb = r[4] ^ b;
        return {r[3], r[2] ^ fb, r[1], r[0] ^ fb, fb};
    endfunction

    function automatic int data_bit_count();
        if (cmd_kind)
            return CMD_DATA_BITS;
        return (pos_bits_reg > MAX_POS_BITS) ? MAX_POS_BITS : int'(pos_bits_reg);
    endfunction

    // advance the protocol state by one encoder clock period and queue its outputs
    task automatic predict_clock_period(input emt_item_t it);
        emt_result_t r;
        int          doc;
        int          i;
        logic [2:0]  st;
        r = '0;
        r.busy_res = 1'b1;
        if (enc_phase == PH_IDLE) begin
            if (!it.start_req) begin
                r.clock_line = 1'b1;
                r.busy_res = 1'b0;
            end
            else
            begin
                cmd_kind = it.mode_type;
                tx_bits = '0;
                tx_bits[5:0] = it.mode_bits;
                if (it.mode_type) begin
                    for (i = 0; i < 8; i++)
                        tx_bits[6 + i] = it.address[7 - i];
                    for (i = 0; i < 16; i++)
                        tx_bits[14 + i] = it.param_word[15 - i];
                end
                sent_addr = it.address;
                rx_bits = '0;
                crc_acc = CRC_SEED;
                crc_in = '0;
                err_flag = 1'b0;
                step_count = '0;
                enc_phase = PH_SEND;
            end
        end
        case (enc_phase)
            PH_SEND:
            begin
                doc = cmd_kind ? SEND_BITS_CMD : SEND_BITS_POS;
                i = step_count;
                r.drive_enable = (i >= 1 && i < doc + 2);
                if (i >= 2 && i < doc + 2)
                    r.data_out_line = tx_bits[i - 2];
                i++;
                if (i >= doc + 4) begin
                    i = 0;
                    enc_phase = PH_WAIT;
                end
                step_count = 6'(i);
            end
            PH_WAIT:
            begin
                if (it.din) begin
                    step_count = '0;
                    enc_phase = cmd_kind ? PH_DATA : PH_FBIT;
                end
            end
            PH_FBIT:
            begin
                err_flag = it.din;
                crc_acc = crc_shift(crc_acc, it.din);
                step_count = '0;
                enc_phase = (data_bit_count() == 0) ? PH_CRC : PH_DATA;
            end
            PH_DATA:
            begin
                crc_acc = crc_shift(crc_acc, it.din);
                if (cmd_kind)
                    rx_bits = {24'b0, rx_bits[22:0], it.din};
                else
                    rx_bits[step_count] = it.din;
                step_count = step_count + 6'd1;
                if (step_count >= data_bit_count()) begin
                    step_count = '0;
                    enc_phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                crc_in = {crc_in[3:0], it.din};
                step_count = step_count + 6'd1;
                if (step_count >= CRC_BITS) begin
                    st = '0;
                    st[STAT_ERR] = err_flag;
                    st[STAT_CRC] = (crc_in != ~crc_acc);
                    if (cmd_kind) begin
                        r.rx_address = rx_bits[23:16];
                        r.rx_data = rx_bits[15:0];
                        st[STAT_ADDR] = (rx_bits[23:16] != sent_addr);
                    end
                    else
                    begin
                        r.position = rx_bits;
                    end
                    last_stat = st;
                    step_count = '0;
                    enc_phase = PH_IDLE;
                    r.clock_line = 1'b1;
                    r.busy_res = 1'b0;
                    r.done_res = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.status = last_stat;
        expected_periods.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatches < 100)
            $display("mismatch on %0s: expected %0h, got %0h", what, want, got);
        mismatches++;
    endtask

    task automatic send_period(input emt_item_t it);
        // idle gap: drop valid, then keep it low while a random draw stays under the idle percentage
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.din, it.param_word, it.address, it.mode_bits, it.start_req};
        s_axis_tuser <= it.mode_type;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_clock_period(it);
        items_sent++;
    endtask

    // period with random command fields; a start here lands on a busy block or is noise
    task automatic send_filler_period(input logic din, input bit may_start);
        emt_item_t it;
        it.start_req = may_start ? 1'($urandom_range(1)) : 1'b0;
        it.mode_type = 1'($urandom_range(1));
        it.mode_bits = 6'($urandom);
        it.address = 8'($urandom);
        it.param_word = 16'($urandom);
        it.din = din;
        send_period(it);
    endtask

    // fill: 0 all zeros, 1 all ones, otherwise random payload
    task automatic run_transfer(input logic kind, input logic [5:0] mbits,
                                input logic [7:0] addr, input logic [15:0] word,
                                input int fill, input bit err_bit, input bit bad_crc,
                                input bit echo_ok, input int wait_zeros);
        emt_item_t   it;
        logic [4:0]  crc;
        logic [23:0] reply;
        logic        b;
        int          doc;
        int          n;
        int          k;
        it.start_req = 1'b1;
        it.mode_type = kind;
        it.mode_bits = mbits;
        it.address = addr;
        it.param_word = word;
        it.din = 1'($urandom_range(1));
        send_period(it);
        doc = kind ? SEND_BITS_CMD : SEND_BITS_POS;
        repeat (doc + 3) send_filler_period(1'($urandom_range(1)), 1'b1);
        repeat (wait_zeros) send_filler_period(1'b0, 1'b1);
        send_filler_period(1'b1, 1'b1);
        crc = CRC_SEED;
        n = data_bit_count();
        reply[23:16] = echo_ok ? addr : addr ^ 8'($urandom_range(1, 255));
        reply[15:0] = (fill == 0) ? 16'h0000 : (fill == 1) ? 16'hFFFF : 16'($urandom);
        if (!kind) begin
            send_filler_period(err_bit, 1'b1);
            crc = crc_shift(crc, err_bit);
        end
        for (k = 0; k < n; k++) begin
            if (kind)
                b = reply[23 - k];
            else
                b = (fill == 0) ? 1'b0 : (fill == 1) ? 1'b1 : 1'($urandom_range(1));
            send_filler_period(b, 1'b1);
            crc = crc_shift(crc, b);
        end
        crc = ~crc;
        if (bad_crc)
            crc = crc ^ (5'd1 << $urandom_range(4));
        for (k = CRC_BITS - 1; k >= 0; k--)
            send_filler_period(crc[k], 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_periods.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_position_bits(input logic [5:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pos_bits_reg = v;
    endtask

    task automatic test_idle_periods();
        emt_item_t it;
        it = '1;
        it.start_req = 1'b0;
        send_period(it);
        it = '0;
        send_period(it);
        repeat (2) send_filler_period(1'($urandom_range(1)), 1'b0);
    endtask

    task automatic test_position_reads();
        run_transfer(1'b0, 6'h00, 8'h00, 16'h0000, 0, 1'b0, 1'b0, 1'b1, 0);
        run_transfer(1'b0, 6'h3F, 8'hFF, 16'hFFFF, 1, 1'b1, 1'b1, 1'b1, 3);
    endtask

    task automatic test_mode_commands();
        run_transfer(1'b1, 6'h38, 8'h00, 16'h0000, 0, 1'b0, 1'b0, 1'b1, 0);
        run_transfer(1'b1, 6'h3F, 8'hFF, 16'hFFFF, 1, 1'b0, 1'b1, 1'b0, 2);
        run_transfer(1'b1, 6'h00, 8'hA5, 16'h5A3C, 2, 1'b0, 1'b0, 1'b1, 1);
    endtask

    // count extremes: single bit, full width, none (crc right after the error bit),
    // and a value above the maximum that saturates
    task automatic test_position_count();
        logic [5:0] counts[4];
        int         k;
        counts = '{6'd1, 6'd48, 6'd0, 6'd63};
        for (k = 0; k < 4; k++) begin
            write_position_bits(counts[k]);
            run_transfer(1'b0, 6'($urandom), 8'($urandom), 16'($urandom), 2,
                         1'($urandom_range(1)), 1'b0, 1'b1, 1);
        end
        write_position_bits(POSITION_BITS_RST);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int         target;
        int         pick;
        logic [5:0] v;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(3) == 0) begin
                pick = $urandom_range(9);
                v = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd63 : (pick == 2) ? 6'd48 :
                    (pick < 6) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(1, 48));
                write_position_bits(v);
            end
            repeat ($urandom_range(2)) send_filler_period(1'($urandom_range(1)), 1'b0);
            run_transfer(1'($urandom_range(1)), 6'($urandom), 8'($urandom), 16'($urandom),
                         ($urandom_range(9) == 0) ? int'($urandom_range(1)) : 2,
                         ($urandom_range(9) < 3), ($urandom_range(9) < 2),
                         ($urandom_range(3) != 0),
                         ($urandom_range(19) == 0) ? int'($urandom_range(12, 20))
                                                   : int'($urandom_range(3)));
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin : check_results
        emt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_periods.size() == 0) begin
                report_mismatch("unexpected result", '0, m_axis_tdata[63:0]);
            end
            else
            begin
                want = expected_periods.pop_front();
                if (m_axis_tdata[0] !== want.clock_line)
                    report_mismatch("clock_line", want.clock_line, m_axis_tdata[0]);
                if (m_axis_tdata[1] !== want.data_out_line)
                    report_mismatch("data_out_line", want.data_out_line, m_axis_tdata[1]);
                if (m_axis_tdata[2] !== want.drive_enable)
                    report_mismatch("drive_enable", want.drive_enable, m_axis_tdata[2]);
                if (m_axis_tdata[3] !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, m_axis_tdata[3]);
                if (m_axis_tdata[4] !== want.done_res)
                    report_mismatch("done_res", want.done_res, m_axis_tdata[4]);
                if (m_axis_tdata[52:5] !== want.position)
                    report_mismatch("position", want.position, m_axis_tdata[52:5]);
                if (m_axis_tdata[60:53] !== want.rx_address)
                    report_mismatch("rx_address", want.rx_address, m_axis_tdata[60:53]);
                if (m_axis_tdata[76:61] !== want.rx_data)
                    report_mismatch("rx_data", want.rx_data, m_axis_tdata[76:61]);
                if (m_axis_tdata[79:77] !== want.status)
                    report_mismatch("status", want.status, m_axis_tdata[79:77]);
            end
        end
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        enc_phase = PH_IDLE;
        step_count = '0;
        tx_bits = '0;
        rx_bits = '0;
        crc_acc = CRC_SEED;
        crc_in = '0;
        err_flag = 1'b0;
        sent_addr = '0;
        cmd_kind = 1'b0;
        last_stat = '0;
        pos_bits_reg = POSITION_BITS_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_periods();
        test_position_reads();
        test_mode_commands();
        test_position_count();
        test_random_traffic(0, 0, 40);
        test_random_traffic(65, 0, 40);
        test_random_traffic(0, 65, 40);
        test_random_traffic(14, 14, 40);

        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
design/emt_pkg.sv
design/emt_in_reg.sv
design/emt_core.sv
design/emt_out_reg.sv
design/endat_master_transceiver_top.sv
verif/tb_endat_master_transceiver_top.sv
